FILE: hdl/bnpe_pkg.sv
// ----------------------------------------------------------------------------
// bnpe_pkg
// Shared constants, types and the sine table builder for the needle estimator.
// ----------------------------------------------------------------------------
package bnpe_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int COUNT_BITS      = 32;
  localparam int TOTAL_BITS      = 32;
  localparam int QUO_BITS        = 32;

  // Q8.24 of 2*t/c is t*2^25/c; quotient saturates once t >= 128*c
  localparam int QUO_FRAC_BITS   = 25;
  localparam int QUO_INT_SHIFT   = QUO_BITS - QUO_FRAC_BITS;

  localparam int SINE_W          = 17;
  localparam int SINE_AW         = SINE_TABLE_BITS + 1;
  localparam int SINE_DEPTH      = (1 << SINE_TABLE_BITS) + 1;
  localparam int SINE_ONE        = 65536;
  localparam int SUM_W           = SINE_W + 1;
  localparam int STEP_W          = $clog2(QUO_BITS);

  localparam int IN_TDATA_W      = 2 * FRACTION_BITS;
  localparam int OUT_TDATA_W     = QUO_BITS + 2 * TOTAL_BITS;
  localparam int OUT_TUSER_W     = 2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_DEPTH-1];

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic load_out;
  } bnpe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } bnpe_status_t;

  // sin(pi/2 * k / 2^SINE_TABLE_BITS) in Q1.16 by a Taylor series in Q2.30
  function automatic logic [SINE_W-1:0] sin_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
    x2 = (x * x) >> 30;
    a  = Q30_ONE - x2 / 110;
    a  = Q30_ONE - ((x2 * a) >> 30) / 72;
    a  = Q30_ONE - ((x2 * a) >> 30) / 42;
    a  = Q30_ONE - ((x2 * a) >> 30) / 20;
    a  = Q30_ONE - ((x2 * a) >> 30) / 6;
    s  = (x * a) >> 30;
    s  = (s + (64'd1 << 13)) >> 14;
    if (s > 64'(SINE_ONE)) begin
      s = 64'(SINE_ONE);
    end
    return s[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sin_entry(k);
    end
    return rom;
  endfunction

endpackage

FILE: hdl/buffon_needle_pi_estimator_top.sv
// ----------------------------------------------------------------------------
// buffon_needle_pi_estimator_top
// Buffon's needle estimate of pi from a stream of random needle throws.
// ----------------------------------------------------------------------------
// Input stream: one transaction per throw; tdata carries the needle center
// position (Q0.16 of line spacing) and the angle (Q0.16 of pi); tlast marks
// the final throw of a run. Throws are taken one per cycle while tready is high.
// Output stream: one transaction per run, after the throw marked last:
// 2*throws/crossings in Q8.24 (clamped), the crossing and throw totals, and
// the no-crossings and saturated flags in tuser.
// The last throw is counted, then the divider is loaded, then a restoring
// divider yields one quotient bit per cycle, and then the result enters the
// output register once that register is free. The input is held off from
// the last throw until the result enters the output register.
// A waiting result does not block new throws; only the hand-off of the next
// run's result waits for the receiver. Reset clears both counters and drops
// any pending result.
// ----------------------------------------------------------------------------
module buffon_needle_pi_estimator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bnpe_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // position, angle
  input  logic                              s_axis_tlast,  // last_sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pi_estimate, crossing_total, throw_total
  output logic [bnpe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic [bnpe_pkg::OUT_TUSER_W-1:0]  m_axis_tuser   // no_crossings, saturated
);

  bnpe_pkg::bnpe_cmd_t    cmd;
  bnpe_pkg::bnpe_status_t status;

  bnpe_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  bnpe_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .status        (status)
  );

endmodule

FILE: hdl/bnpe_ctrl.sv
// ----------------------------------------------------------------------------
// bnpe_ctrl
// Sequencer: accepts throws, then drains, divides and hands off the result.
// ----------------------------------------------------------------------------
module bnpe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tlast,
  output logic                  s_axis_tready,
  input  bnpe_pkg::bnpe_status_t status,
  output bnpe_pkg::bnpe_cmd_t   cmd
);

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_CNT  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == ST_RUN);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.accept   = s_axis_tvalid && s_axis_tready;
    unique case (state)
      ST_RUN: begin
        if (cmd.accept && s_axis_tlast) begin
          state_next = ST_CNT;
        end
      end
      ST_CNT: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_div = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/bnpe_datapath.sv
// ----------------------------------------------------------------------------
// bnpe_datapath
// Sine lookup, crossing test, run counters, serial divider, output register.
// ----------------------------------------------------------------------------
module bnpe_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bnpe_pkg::bnpe_cmd_t                   cmd,
  input  logic [bnpe_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [bnpe_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [bnpe_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  output bnpe_pkg::bnpe_status_t                status
);

  localparam bnpe_pkg::sine_rom_t SINE_ROM = bnpe_pkg::build_sine_rom();
  localparam logic [bnpe_pkg::SINE_AW-1:0] QUARTER =
    bnpe_pkg::SINE_AW'(1 << bnpe_pkg::SINE_TABLE_BITS);
  localparam logic [bnpe_pkg::SUM_W-1:0] SINE_TWO =
    bnpe_pkg::SUM_W'(2 * bnpe_pkg::SINE_ONE);

  logic [bnpe_pkg::FRACTION_BITS-1:0] position;
  logic [bnpe_pkg::FRACTION_BITS-1:0] angle;
  logic [bnpe_pkg::SINE_AW-1:0]       half_idx;
  logic [bnpe_pkg::SINE_AW-1:0]       rom_addr;

  // lookup stage
  logic                               v1;
  logic [bnpe_pkg::FRACTION_BITS-1:0] pos_q;
  logic [bnpe_pkg::SINE_W-1:0]        sine_q;

  // crossing test
  logic [bnpe_pkg::SINE_W-1:0]        pos2;
  logic [bnpe_pkg::SUM_W-1:0]         edge_sum;
  logic                               crossed;

  logic [bnpe_pkg::COUNT_BITS-1:0]    throw_cnt;
  logic [bnpe_pkg::COUNT_BITS-1:0]    cross_cnt;

  // divider
  logic [bnpe_pkg::QUO_BITS-1:0]      rem;
  logic [bnpe_pkg::QUO_BITS-1:0]      quo;
  logic [bnpe_pkg::QUO_BITS-1:0]      dvd_bits;
  logic [bnpe_pkg::COUNT_BITS-1:0]    dvs;
  logic [bnpe_pkg::COUNT_BITS-1:0]    t_tot;
  logic                               sat_q;
  logic                               zero_q;
  logic [bnpe_pkg::STEP_W-1:0]        step_cnt;
  logic [bnpe_pkg::QUO_BITS:0]        trial;
  logic                               trial_ge;
  logic [bnpe_pkg::QUO_BITS-1:0]      pi_val;

  assign position = s_axis_tdata[bnpe_pkg::FRACTION_BITS-1:0];
  assign angle    = s_axis_tdata[bnpe_pkg::IN_TDATA_W-1:bnpe_pkg::FRACTION_BITS];
  assign half_idx = angle[bnpe_pkg::FRACTION_BITS-1 -: bnpe_pkg::SINE_AW];

  always_comb begin
    if (half_idx > QUARTER) begin
      rom_addr = (~half_idx) + 1'b1;
    end else begin
      rom_addr = half_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sine_q <= SINE_ROM[rom_addr];
      pos_q  <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.accept;
    end
  end

  // 2x - s < 0 or 2x + s > 2, on the Q1.16 grid of the sine
  assign pos2     = {pos_q, 1'b0};
  assign edge_sum = bnpe_pkg::SUM_W'(pos2) + bnpe_pkg::SUM_W'(sine_q);
  assign crossed  = (pos2 < sine_q) || (edge_sum > SINE_TWO);

  always_ff @(posedge clk) begin
    if (rst) begin
      throw_cnt <= '0;
      cross_cnt <= '0;
    end else if (cmd.load_div) begin
      throw_cnt <= '0;
      cross_cnt <= '0;
    end else if (v1) begin
      if (throw_cnt != '1) begin
        throw_cnt <= throw_cnt + 1'b1;
      end
      if (crossed && cross_cnt != '1) begin
        cross_cnt <= cross_cnt + 1'b1;
      end
    end
  end

  // restoring division of t*2^25 by c, one quotient bit a cycle
  assign trial    = {rem, dvd_bits[bnpe_pkg::QUO_BITS-1]};
  assign trial_ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem      <= bnpe_pkg::QUO_BITS'(throw_cnt >> bnpe_pkg::QUO_INT_SHIFT);
      dvd_bits <= bnpe_pkg::QUO_BITS'(throw_cnt << bnpe_pkg::QUO_FRAC_BITS);
      quo      <= '0;
      dvs      <= cross_cnt;
      t_tot    <= throw_cnt;
      sat_q    <= (throw_cnt >> bnpe_pkg::QUO_INT_SHIFT) >= cross_cnt;
      zero_q   <= (cross_cnt == '0);
    end else if (cmd.div_step) begin
      if (trial_ge) begin
        rem <= bnpe_pkg::QUO_BITS'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[bnpe_pkg::QUO_BITS-1:0];
      end
      quo      <= {quo[bnpe_pkg::QUO_BITS-2:0], trial_ge};
      dvd_bits <= dvd_bits << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load_div) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  assign status.div_done = (step_cnt == '1);
  assign status.out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    priority if (zero_q) begin
      pi_val = '0;
    end else if (sat_q) begin
      pi_val = '1;
    end else begin
      pi_val = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= {t_tot, dvs, pi_val};
      m_axis_tuser <= {sat_q && !zero_q, zero_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
